// ===== rtl/csvfs_pkg.sv =====
// Shared constants, result type and character class helper for the CSV field splitter.
package csvfs_pkg;

	localparam int POSITION_BITS_DEF = 16;
	localparam int OFFSET_W          = 16;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	typedef struct packed {
		logic [OFFSET_W-1:0] kept_first;
		logic [OFFSET_W-1:0] kept_end;
		logic                field_empty;
		logic                last_field;
		logic                overflow;
	} field_res_t;

	function automatic logic is_trimmed(input logic [7:0] c);
		logic hit;
		case (c)
			CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_QUOTE: hit = 1'b1;
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

endpackage

// ===== rtl/csvfs_field_core.sv =====
// Per-byte quote tracking, trimming and field boundary logic with line state registers.
module csvfs_field_core import csvfs_pkg::*; #(
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] text_byte,
	input  logic       line_end,
	output logic       res_valid,
	output field_res_t res
);

	// offsets never exceed 16 bits, whatever the parameter
	localparam int PW = (POSITION_BITS > OFFSET_W) ? OFFSET_W : POSITION_BITS;
	localparam logic [PW-1:0] POS_LIMIT = {PW{1'b1}};

	logic          quote_parity_q;
	logic          prev_bs_q;
	logic [PW-1:0] line_pos_q;
	logic [PW-1:0] first_kept_q;
	logic [PW-1:0] end_kept_q;
	logic          seen_kept_q;
	logic          pos_ovf_q;

	logic          at_limit;
	logic          ovf;
	logic [PW-1:0] pos_inc;
	logic          parity_n;
	logic          split;
	logic          kept;
	logic          seen_n;
	logic [PW-1:0] first_n;
	logic [PW-1:0] end_n;
	logic          emit_seen;
	logic [PW-1:0] emit_first;
	logic [PW-1:0] emit_end;

	always_comb begin
		at_limit = (line_pos_q == POS_LIMIT);
		ovf      = pos_ovf_q | at_limit;
		pos_inc  = at_limit ? POS_LIMIT : line_pos_q + PW'(1);
		parity_n = quote_parity_q ^ ((text_byte == CH_QUOTE) & ~prev_bs_q);
		split    = (text_byte == CH_COMMA) & ~parity_n;
		kept     = ~is_trimmed(text_byte);

		if (split) begin
			seen_n  = 1'b0;
			first_n = '0;
			end_n   = '0;
		end else begin
			seen_n  = seen_kept_q | kept;
			first_n = (kept & ~seen_kept_q) ? line_pos_q : first_kept_q;
			end_n   = kept ? pos_inc : end_kept_q;
		end

		// a splitting comma reports the field it closes, otherwise the updated one
		emit_seen  = split ? seen_kept_q : seen_n;
		emit_first = split ? first_kept_q : first_n;
		emit_end   = split ? end_kept_q : end_n;

		res_valid       = accept & (split | line_end);
		res.kept_first  = emit_seen ? OFFSET_W'(emit_first) : '0;
		res.kept_end    = emit_seen ? OFFSET_W'(emit_end) : '0;
		res.field_empty = ~emit_seen;
		res.last_field  = line_end;
		res.overflow    = ovf;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quote_parity_q <= 1'b0;
			prev_bs_q      <= 1'b0;
			line_pos_q     <= '0;
			first_kept_q   <= '0;
			end_kept_q     <= '0;
			seen_kept_q    <= 1'b0;
			pos_ovf_q      <= 1'b0;
		end else if (accept) begin
			if (line_end) begin
				quote_parity_q <= 1'b0;
				prev_bs_q      <= 1'b0;
				line_pos_q     <= '0;
				first_kept_q   <= '0;
				end_kept_q     <= '0;
				seen_kept_q    <= 1'b0;
				pos_ovf_q      <= 1'b0;
			end else begin
				quote_parity_q <= parity_n;
				prev_bs_q      <= (text_byte == CH_BSLASH);
				line_pos_q     <= pos_inc;
				first_kept_q   <= first_n;
				end_kept_q     <= end_n;
				seen_kept_q    <= seen_n;
				pos_ovf_q      <= ovf;
			end
		end
	end

	a_line_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && line_end) |=> (line_pos_q == '0 && !quote_parity_q && !seen_kept_q
			&& !pos_ovf_q && !prev_bs_q))
		else $error("line state not cleared after final byte");

	a_empty_offsets_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!seen_kept_q |-> (first_kept_q == '0 && end_kept_q == '0))
		else $error("offsets held without a kept byte");

	a_end_not_before_first: assert property (@(posedge clk) disable iff (!arst_n)
		seen_kept_q |-> (end_kept_q > first_kept_q || end_kept_q == POS_LIMIT))
		else $error("kept end precedes kept start");

	a_result_only_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> accept)
		else $error("result raised without an accepted item");

endmodule

// ===== rtl/csvfs_out_buf.sv =====
// Output register with a skid stage between field results and the downstream channel.
module csvfs_out_buf import csvfs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       res_valid,
	input  field_res_t res,
	output logic       full,
	output logic       out_valid,
	input  logic       out_stall,
	output field_res_t out_res
);

	logic       out_valid_q;
	field_res_t out_res_q;
	logic       skid_valid_q;
	field_res_t skid_res_q;
	logic       take;

	assign take      = out_valid_q & ~out_stall;
	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (res_valid) begin
			if (!out_valid_q || take) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_res_q <= skid_res_q;
			end
		end else if (res_valid) begin
			if (!out_valid_q || take) begin
				out_res_q <= res;
			end else begin
				skid_res_q <= res;
			end
		end
	end

	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid item held while output register empty");

	a_skid_moves_up: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && take) |=> (out_valid_q && !skid_valid_q))
		else $error("skid item not moved to output");

	a_no_write_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> !res_valid)
		else $error("result offered while buffer full");

endmodule

// ===== rtl/csv_field_splitter.sv =====
// Top level of the CSV field splitter.
// One byte of a line is accepted per cycle unless stalled, with line_end on its final
// byte. Each splitting comma (one outside an odd count of unescaped double quotes) and the
// final byte give one field result with trimmed start/end offsets; a line ending in a
// splitting comma gives no extra trailing field. Per-byte work is a single pass of
// compares and one increment; results are registered in a two-entry output buffer that
// lets bytes keep flowing while a result waits; text_stall rises only when both entries
// are held. Offsets saturate at 2^POSITION_BITS-1 (at most 65535).
module csv_field_splitter import csvfs_pkg::*; #(
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                text_valid,
	output logic                text_stall,
	input  logic [7:0]          text_byte,
	input  logic                line_end,
	output logic                field_valid,
	input  logic                field_stall,
	output logic [OFFSET_W-1:0] kept_first,
	output logic [OFFSET_W-1:0] kept_end,
	output logic                field_empty,
	output logic                last_field,
	output logic                overflow
);

	logic       accept;
	logic       res_valid;
	field_res_t res;
	logic       buf_full;
	field_res_t out_res;

	assign text_stall = buf_full;
	assign accept     = text_valid & ~buf_full;

	csvfs_field_core #(
		.POSITION_BITS(POSITION_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.text_byte(text_byte),
		.line_end (line_end),
		.res_valid(res_valid),
		.res      (res)
	);

	csvfs_out_buf u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_valid(res_valid),
		.res      (res),
		.full     (buf_full),
		.out_valid(field_valid),
		.out_stall(field_stall),
		.out_res  (out_res)
	);

	assign kept_first  = out_res.kept_first;
	assign kept_end    = out_res.kept_end;
	assign field_empty = out_res.field_empty;
	assign last_field  = out_res.last_field;
	assign overflow    = out_res.overflow;

endmodule
